### rtl/core/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, constants and byte helpers for the ARP request responder.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

    localparam int unsigned REPLY_LEN = 42;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned IDX_W     = 1;
    localparam int unsigned CFG_W     = 48;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_OWN_MAC = 1'b0;
    localparam logic [IDX_W-1:0] REG_OWN_IP  = 1'b1;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [15:0] OP_REPLY      = 16'h0002;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPLY_LEN - 1);
    localparam logic [POS_W-1:0] FULL_POS = POS_W'(REPLY_LEN);

    typedef enum logic {
        ST_RX,
        ST_TX
    } arp_state_t;

    typedef struct packed {
        logic rx_take;   // frame byte transfer this cycle
        logic tx_start;  // load reply index with zero
        logic tx_step;   // reply byte transfer this cycle
    } arp_cmd_t;

    typedef struct packed {
        logic reply_ok;  // current byte ends a matching frame
        logic tx_last;   // reply index at final byte
    } arp_stat_t;

    // byte i of a 48-bit big-endian value
    function automatic logic [7:0] be6(input logic [47:0] v, input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0:    r = v[47:40];
            3'd1:    r = v[39:32];
            3'd2:    r = v[31:24];
            3'd3:    r = v[23:16];
            3'd4:    r = v[15:8];
            3'd5:    r = v[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // byte i of a 32-bit big-endian value
    function automatic logic [7:0] be4(input logic [31:0] v, input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0:    r = v[31:24];
            2'd1:    r = v[23:16];
            2'd2:    r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

    // header check for one received byte at position p
    function automatic logic byte_ok(input logic [POS_W-1:0] p, input logic [7:0] b,
                                     input logic [31:0] own_ip);
        logic ok;
        unique case (p)
            6'd12:   ok = (b == ETHERTYPE_ARP[15:8]);
            6'd13:   ok = (b == ETHERTYPE_ARP[7:0]);
            6'd14:   ok = (b == HTYPE_ETH[15:8]);
            6'd15:   ok = (b == HTYPE_ETH[7:0]);
            6'd16:   ok = (b == PTYPE_IPV4[15:8]);
            6'd17:   ok = (b == PTYPE_IPV4[7:0]);
            6'd20:   ok = (b == OP_REQUEST[15:8]);
            6'd21:   ok = (b == OP_REQUEST[7:0]);
            6'd38:   ok = (b == own_ip[31:24]);
            6'd39:   ok = (b == own_ip[23:16]);
            6'd40:   ok = (b == own_ip[15:8]);
            6'd41:   ok = (b == own_ip[7:0]);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    // reply byte k
    function automatic logic [7:0] reply_at(input logic [POS_W-1:0] k,
                                            input logic [47:0] req_mac,
                                            input logic [31:0] req_ip,
                                            input logic [47:0] hdr,
                                            input logic [47:0] own_mac,
                                            input logic [31:0] own_ip);
        logic [7:0] r;
        priority if (k < 6'd6)   r = be6(req_mac, 3'(k));
        else if (k < 6'd12)      r = be6(own_mac, 3'(k - 6'd6));
        else if (k == 6'd12)     r = ETHERTYPE_ARP[15:8];
        else if (k == 6'd13)     r = ETHERTYPE_ARP[7:0];
        else if (k < 6'd20)      r = be6(hdr, 3'(k - 6'd14));
        else if (k == 6'd20)     r = OP_REPLY[15:8];
        else if (k == 6'd21)     r = OP_REPLY[7:0];
        else if (k < 6'd28)      r = be6(own_mac, 3'(k - 6'd22));
        else if (k < 6'd32)      r = be4(own_ip, 2'(k - 6'd28));
        else if (k < 6'd38)      r = be6(req_mac, 3'(k - 6'd32));
        else                     r = be4(req_ip, 2'(k - 6'd38));
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/arp_frame_if.sv
// ----------------------------------------------------------------------------
// arp_frame_if
// Received frame byte channel: valid/ready with byte and end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface arp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;

    modport source (output valid, output frame_byte, output end_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/core/arp_reply_if.sv
// ----------------------------------------------------------------------------
// arp_reply_if
// Reply byte channel: valid/ready with byte and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface arp_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_last;

    modport source (output valid, output reply_byte, output reply_last, input ready);
    modport sink   (input valid, input reply_byte, input reply_last, output ready);
endinterface

`default_nettype wire

### rtl/core/arp_ctrl.sv
// ----------------------------------------------------------------------------
// arp_ctrl
// Receive/transmit sequencer for the ARP responder.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              frame_valid,
    input  wire logic              frame_end,
    input  wire logic              reply_ready,
    input  wire arp_pkg::arp_stat_t stat,
    output arp_pkg::arp_cmd_t      cmd,
    output logic                   frame_ready,
    output logic                   reply_valid
);

    arp_pkg::arp_state_t state_reg;
    arp_pkg::arp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arp_pkg::ST_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arp_pkg::ST_RX:
            begin
                if (frame_valid && frame_end && stat.reply_ok)
                begin
                    state_next = arp_pkg::ST_TX;
                end
            end
            arp_pkg::ST_TX:
            begin
                if (reply_ready && stat.tx_last)
                begin
                    state_next = arp_pkg::ST_RX;
                end
            end
            default: state_next = arp_pkg::ST_RX;
        endcase
    end

    always_comb
    begin
        frame_ready  = (state_reg == arp_pkg::ST_RX);
        reply_valid  = (state_reg == arp_pkg::ST_TX);
        cmd.rx_take  = frame_ready && frame_valid;
        cmd.tx_start = cmd.rx_take && frame_end && stat.reply_ok;
        cmd.tx_step  = reply_valid && reply_ready;
    end

endmodule

`default_nettype wire

### rtl/core/arp_datapath.sv
// ----------------------------------------------------------------------------
// arp_datapath
// Frame parsing, field capture, station registers and reply byte select.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [arp_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [arp_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic [7:0]                      frame_byte,
    input  wire logic                            frame_end,
    input  wire arp_pkg::arp_cmd_t               cmd,
    output arp_pkg::arp_stat_t                   stat,
    output logic [7:0]                           reply_byte,
    output logic                                 reply_last
);

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [arp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic match_reg, match_next;
    logic [47:0] hdr_reg, hdr_next;
    logic [47:0] rmac_reg, rmac_next;
    logic [31:0] rip_reg, rip_next;
    logic [arp_pkg::POS_W-1:0] tx_idx_reg, tx_idx_next;

    logic                      in_win;
    logic [arp_pkg::POS_W-1:0] pos_inc;
    logic                      match_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == arp_pkg::REG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data[47:0];
            end
            if (cfg_index == arp_pkg::REG_OWN_IP)
            begin
                own_ip_reg <= cfg_data[31:0];
            end
        end
    end

    // position saturates once the reply length is reached
    assign in_win    = (pos_reg < arp_pkg::FULL_POS);
    assign pos_inc   = in_win ? pos_reg + 1'b1 : pos_reg;
    assign match_inc = match_reg &&
                       (!in_win || arp_pkg::byte_ok(pos_reg, frame_byte, own_ip_reg));

    always_comb
    begin
        pos_next   = pos_reg;
        match_next = match_reg;
        hdr_next   = hdr_reg;
        rmac_next  = rmac_reg;
        rip_next   = rip_reg;
        if (cmd.rx_take)
        begin
            pos_next   = pos_inc;
            match_next = match_inc;
            if (pos_reg >= 6'd14 && pos_reg < 6'd20)
            begin
                hdr_next = {hdr_reg[39:0], frame_byte};
            end
            if (pos_reg >= 6'd22 && pos_reg < 6'd28)
            begin
                rmac_next = {rmac_reg[39:0], frame_byte};
            end
            if (pos_reg >= 6'd28 && pos_reg < 6'd32)
            begin
                rip_next = {rip_reg[23:0], frame_byte};
            end
            if (frame_end)
            begin
                pos_next   = '0;
                match_next = 1'b1;
            end
        end
    end

    // captured fields are fully rewritten before any reply, so no reset
    always_ff @(posedge clk)
    begin
        hdr_reg  <= hdr_next;
        rmac_reg <= rmac_next;
        rip_reg  <= rip_next;
    end

    always_comb
    begin
        tx_idx_next = tx_idx_reg;
        if (cmd.tx_start)
        begin
            tx_idx_next = '0;
        end
        else if (cmd.tx_step)
        begin
            tx_idx_next = tx_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            match_reg  <= 1'b1;
            tx_idx_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            tx_idx_reg <= tx_idx_next;
        end
    end

    always_comb
    begin
        stat.reply_ok = frame_end && (pos_inc == arp_pkg::FULL_POS) && match_inc;
        stat.tx_last  = (tx_idx_reg == arp_pkg::LAST_POS);
        reply_last    = stat.tx_last;
        reply_byte    = arp_pkg::reply_at(tx_idx_reg, rmac_reg, rip_reg, hdr_reg,
                                          own_mac_reg, own_ip_reg);
    end

endmodule

`default_nettype wire

### rtl/core/arp_request_responder.sv
// ----------------------------------------------------------------------------
// arp_request_responder
// Answers Ethernet/IPv4 ARP requests for the station's own address.
//
// Usage:
//   frame  : received frame bytes in wire order, one per transfer, with
//            end_of_frame set on the final byte. Accepted one per cycle
//            while the block is receiving.
//   reply  : 42-byte ARP reply, reply_last on the final byte.
//   cfg_*  : own_mac (index 0) and own_ip (index 1); write while idle.
// Latency: the first reply byte is valid the cycle after the transfer of
//   the final frame byte of a matching request. The reply then moves at
//   one byte per cycle while reply.ready is high.
// Throughput: one frame byte per cycle; during a reply frame.ready is low
//   until the 42nd reply byte transfers, since the reply index counter and
//   the captured requester fields are single-buffered.
// Reset: station registers clear to zero, frame state clears, the block
//   comes up receiving. A stalled reply holds its byte and index.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_request_responder (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [arp_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [arp_pkg::CFG_W-1:0] cfg_data,
    arp_frame_if.sink                      frame,
    arp_reply_if.source                    reply
);

    arp_pkg::arp_cmd_t  cmd;
    arp_pkg::arp_stat_t stat;

    // sequencer: owns both handshakes
    arp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame.valid),
        .frame_end   (frame.end_of_frame),
        .reply_ready (reply.ready),
        .stat        (stat),
        .cmd         (cmd),
        .frame_ready (frame.ready),
        .reply_valid (reply.valid)
    );

    // parse, capture, and reply byte mux
    arp_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame_byte (frame.frame_byte),
        .frame_end  (frame.end_of_frame),
        .cmd        (cmd),
        .stat       (stat),
        .reply_byte (reply.reply_byte),
        .reply_last (reply.reply_last)
    );

    // receive and transmit never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(frame.ready && reply.valid))
        else $error("receive and reply active together");

    // a reply only starts after the final byte of a frame
    a_start_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(reply.valid) |-> $past(frame.valid && frame.ready && frame.end_of_frame))
        else $error("reply started without end of frame");

    // last reply byte returns the block to receive
    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (reply.valid && reply.ready && reply.reply_last) |=> frame.ready)
        else $error("no return to receive after last reply byte");

    // a non-final reply byte is followed by another
    a_reply_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (reply.valid && reply.ready && !reply.reply_last) |=> reply.valid)
        else $error("reply cut short");

endmodule

`default_nettype wire
